// ----- design/zone_alarm_controller_core_assert.svh -----
// Assertion macros shared by the alarm controller modules.
`ifndef ZONE_ALARM_CONTROLLER_CORE_ASSERT_SVH
`define ZONE_ALARM_CONTROLLER_CORE_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define ZAC_ASSERT_HOLD(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence checked in the same cycle as its antecedent.
`define ZAC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after its antecedent.
`define ZAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/zac_pkg.sv -----
// Types, constants and codes of the zone alarm controller.
package zac_pkg;

  // Field widths
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned ZONES      = 4;
  localparam int unsigned TSEC_W     = 17;
  localparam int unsigned TICK_W     = 17;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned STICK_W    = 7;
  localparam int unsigned ZONE_ID_W  = 3;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned QUEUE_DEPTH = 4;

  // One tick is TICK_NUM / TICK_DEN seconds.
  localparam int unsigned TICK_NUM_W = 14;
  localparam logic [TICK_NUM_W-1:0] TICK_NUM = 14'd13107;
  localparam logic [TICK_NUM_W-1:0] TICK_DEN = 14'd15625;

  // Seconds to ticks: q ~ tsec * SET_RECIP >> SET_SHIFT, then one correction.
  localparam int unsigned SET_SHIFT   = 20;
  localparam int unsigned SET_RECIP_W = 21;
  localparam logic [63:0] SET_RECIP_L = (64'd15625 << SET_SHIFT) / 64'd13107;
  localparam logic [SET_RECIP_W-1:0] SET_RECIP = SET_RECIP_L[SET_RECIP_W-1:0];
  localparam int unsigned SET_PROD_W  = TSEC_W + SET_RECIP_W;
  localparam int unsigned SET_Q_W     = SET_PROD_W - SET_SHIFT;
  localparam int unsigned SET_N_W     = TSEC_W + TICK_NUM_W;

  // Ticks to seconds: q ~ p * SEC_RECIP >> SEC_SHIFT, then one correction.
  localparam int unsigned SEC_P_W     = TICK_W + TICK_NUM_W;
  localparam int unsigned SEC_SHIFT   = 33;
  localparam int unsigned SEC_RECIP_W = 20;
  localparam logic [63:0] SEC_RECIP_L = (64'd1 << SEC_SHIFT) / 64'd15625;
  localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = SEC_RECIP_L[SEC_RECIP_W-1:0];
  localparam int unsigned SEC_PROD_W  = SEC_P_W + SEC_RECIP_W;

  // Exact division by 60 through a rounded-up reciprocal.
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MTOT_W        = 12;
  localparam int unsigned HTOT_W        = 6;
  localparam int unsigned MIN_SHIFT     = 23;
  localparam int unsigned MIN_RECIP_W   = 18;
  localparam logic [63:0] MIN_RECIP_L   = ((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_L[MIN_RECIP_W-1:0];
  localparam int unsigned MIN_PROD_W    = TICK_W + MIN_RECIP_W;
  localparam int unsigned HR_SHIFT      = 18;
  localparam int unsigned HR_RECIP_W    = 13;
  localparam logic [63:0] HR_RECIP_L    = ((64'd1 << HR_SHIFT) + 64'd59) / 64'd60;
  localparam logic [HR_RECIP_W-1:0] HR_RECIP = HR_RECIP_L[HR_RECIP_W-1:0];
  localparam int unsigned HR_PROD_W     = MTOT_W + HR_RECIP_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLOCK    = 3'd0,
    ACT_SIREN    = 3'd1,
    ACT_PWM      = 3'd2,
    ACT_ZONE     = 3'd3,
    ACT_ARM      = 3'd4,
    ACT_DISARM   = 3'd5,
    ACT_SET_TIME = 3'd6
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_HIGH  = 3'd0,
    CFG_DUTY_LOW   = 3'd1,
    CFG_START_DUTY = 3'd2,
    CFG_SIREN_TICK = 3'd3,
    CFG_DAY_TICKS  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_high;
    logic [DUTY_W-1:0]  duty_low;
    logic [DUTY_W-1:0]  start_duty;
    logic [STICK_W-1:0] siren_ticks;
    logic [TICK_W-1:0]  day_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    duty_high:   10'd1000,
    duty_low:    10'd500,
    start_duty:  10'd255,
    siren_ticks: 7'd100,
    day_ticks:   17'd102998
  };

  // State after one executed item, handed from front to back.
  typedef struct packed {
    logic [ZONES-1:0]  fired;
    logic [TICK_W-1:0] ticks;
    logic [DUTY_W-1:0] duty;
    logic              armed;
    logic              siren_on;
  } snap_t;

endpackage

// ----- design/zac_if.sv -----
// Input and result channel interfaces of the alarm controller.
interface zac_in_if;
  import zac_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ZONES-1:0]    zone_levels;
  logic [TSEC_W-1:0]   time_seconds;

  modport source (output valid, action, zone_levels, time_seconds, input ready);
  modport sink   (input valid, action, zone_levels, time_seconds, output ready);
endinterface

interface zac_out_if;
  import zac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 alarm_event;
  logic [ZONE_ID_W-1:0] fired_zone;
  logic [HOUR_W-1:0]    hours;
  logic [MIN_W-1:0]     minutes;
  logic [SEC_W-1:0]     seconds_out;
  logic [DUTY_W-1:0]    duty;
  logic                 armed_out;
  logic                 siren_on;
  logic                 last;

  modport source (output valid, alarm_event, fired_zone, hours, minutes, seconds_out, duty,
                  armed_out, siren_on, last, input ready);
  modport sink   (input valid, alarm_event, fired_zone, hours, minutes, seconds_out, duty,
                  armed_out, siren_on, last, output ready);
endinterface

// ----- design/zac_queue.sv -----
// Small register queue of executed-state snapshots between front and back.
`include "zone_alarm_controller_core_assert.svh"

module zac_queue #(
  parameter int unsigned DEPTH = zac_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  zac_pkg::snap_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          avail_o,
  output zac_pkg::snap_t data_o
);
  import zac_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  snap_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign avail_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `ZAC_ASSERT_HOLD(a_q_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `ZAC_ASSERT_HOLD(a_q_no_underflow, clk_i, rst_ni, !(pop_i && !avail_o), "pop from empty queue")

endmodule

// ----- design/zac_front.sv -----
// Front: accept items, convert set-time seconds to ticks, execute the alarm state.
`include "zone_alarm_controller_core_assert.svh"

module zac_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  zac_in_if.sink         in_i,
  input  zac_pkg::cfg_t  cfg_i,
  input  logic           full_i,
  output logic           push_o,
  output zac_pkg::snap_t snap_o
);
  import zac_pkg::*;

  logic                     adv;
  logic                     v1_q, v2_q, v3_q;
  logic [ACTION_W-1:0]      act1_q, act2_q, act3_q;
  logic [ZONES-1:0]         lev1_q, lev2_q, lev3_q;
  logic [SET_Q_W-1:0]       q1_q, q2_q, c3_q;
  logic [SET_N_W-1:0]       n1_q, n2_q, t2_q, r2;
  logic [SET_PROD_W-1:0]    a_prod;
  logic [SET_Q_W+TICK_NUM_W-1:0] t_prod;

  logic [TICK_W-1:0]  cnt_q, cnt_d;
  logic               armed_q, armed_d;
  logic [ZONES-1:0]   prev_q, prev_d;
  logic [STICK_W-1:0] scount_q, scount_d;
  logic               running_q, running_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic               up_q, up_d;
  logic [ZONES-1:0]   fired;
  logic [TICK_W:0]    tick_inc;
  logic [STICK_W:0]   siren_inc;

  // Advance the whole pipe when its last stage can hand off.
  assign adv        = !v3_q || !full_i;
  assign in_i.ready = adv;
  assign push_o     = v3_q && !full_i;

  assign a_prod = SET_PROD_W'(in_i.time_seconds) * SET_PROD_W'(SET_RECIP);
  assign t_prod = (SET_Q_W + TICK_NUM_W)'(q1_q) * (SET_Q_W + TICK_NUM_W)'(TICK_NUM);
  assign r2     = n2_q - t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act1_q <= in_i.action;
      lev1_q <= in_i.zone_levels;
      q1_q   <= a_prod[SET_SHIFT +: SET_Q_W];
      n1_q   <= SET_N_W'(in_i.time_seconds) * SET_N_W'(TICK_DEN);
      act2_q <= act1_q;
      lev2_q <= lev1_q;
      q2_q   <= q1_q;
      n2_q   <= n1_q;
      t2_q   <= t_prod[SET_N_W-1:0];
      act3_q <= act2_q;
      lev3_q <= lev2_q;
      // Estimate is exact or one short; fix it with the remainder.
      c3_q   <= q2_q + SET_Q_W'(r2 >= SET_N_W'(TICK_NUM));
    end
  end

  assign tick_inc  = {1'b0, cnt_q} + (TICK_W + 1)'(1);
  assign siren_inc = {1'b0, scount_q} + (STICK_W + 1)'(1);

  always_comb begin
    cnt_d     = cnt_q;
    armed_d   = armed_q;
    prev_d    = prev_q;
    scount_d  = scount_q;
    running_d = running_q;
    duty_d    = duty_q;
    up_d      = up_q;
    fired     = '0;
    if (push_o) begin
      unique case (act3_q)
        ACT_CLOCK: begin
          cnt_d = (tick_inc >= {1'b0, cfg_i.day_ticks}) ? '0 : tick_inc[TICK_W-1:0];
        end
        ACT_SIREN: begin
          if (running_q) begin
            scount_d = siren_inc[STICK_W-1:0];
            if (siren_inc >= {1'b0, cfg_i.siren_ticks}) begin
              duty_d    = '0;
              running_d = 1'b0;
            end
          end
        end
        ACT_PWM: begin
          if (duty_q != '0) begin
            if (up_q) begin
              if (duty_q < cfg_i.duty_high) duty_d = duty_q + DUTY_W'(1);
              else up_d = 1'b0;
            end else begin
              if (duty_q > cfg_i.duty_low) duty_d = duty_q - DUTY_W'(1);
              else up_d = 1'b1;
            end
          end
        end
        ACT_ZONE: begin
          fired = armed_q ? (lev3_q & ~prev_q) : '0;
          if (|fired) begin
            duty_d    = cfg_i.start_duty;
            scount_d  = '0;
            running_d = 1'b1;
          end
          prev_d = lev3_q;
        end
        ACT_ARM:    armed_d = 1'b1;
        ACT_DISARM: armed_d = 1'b0;
        ACT_SET_TIME: begin
          cnt_d = (c3_q >= {1'b0, cfg_i.day_ticks}) ? '0 : c3_q[TICK_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      armed_q   <= 1'b0;
      prev_q    <= '0;
      scount_q  <= '0;
      running_q <= 1'b0;
      duty_q    <= '0;
      up_q      <= 1'b1;
    end else begin
      cnt_q     <= cnt_d;
      armed_q   <= armed_d;
      prev_q    <= prev_d;
      scount_q  <= scount_d;
      running_q <= running_d;
      duty_q    <= duty_d;
      up_q      <= up_d;
    end
  end

  assign snap_o = '{fired: fired, ticks: cnt_d, duty: duty_d, armed: armed_d,
                    siren_on: running_d};

  `ZAC_ASSERT_HOLD(a_fe_idle_silent, clk_i, rst_ni, running_q || (duty_q == '0),
                   "siren duty nonzero while siren is off")
  `ZAC_ASSERT_IMPLY(a_fe_fire_armed, clk_i, rst_ni, push_o && (snap_o.fired != '0),
                    (act3_q == ACT_ZONE) && armed_q, "zone fired outside an armed sample")

endmodule

// ----- design/zac_back.sv -----
// Back: turn tick counts into hh:mm:ss and fan each snapshot out into results.
`include "zone_alarm_controller_core_assert.svh"

module zac_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  zac_pkg::snap_t snap_i,
  output logic           pop_o,
  zac_out_if.source      out_o
);
  import zac_pkg::*;

  function automatic logic [ZONE_ID_W-1:0] zone_id(input logic [ZONES-1:0] m);
    logic [ZONE_ID_W-1:0] id;
    id = '0;
    for (int i = ZONES - 1; i >= 0; i--) begin
      if (m[i]) id = ZONE_ID_W'(i + 1);
    end
    return id;
  endfunction

  logic                  en, take, last_w;
  logic                  v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  snap_t                 sn1_q, sn2_q, sn3_q, sn4_q, sn5_q, sn6_q;
  logic [SEC_P_W-1:0]    p1_q, p2_q, p3_q, t3_q, r4;
  logic [SEC_PROD_W-1:0] sec_prod;
  logic [TICK_W-1:0]     q2_q, q3_q, s4_q, s5_q, ss_full;
  logic [MIN_PROD_W-1:0] min_prod;
  logic [HR_PROD_W-1:0]  hr_prod;
  logic [MTOT_W-1:0]     m5_q, m6_q, mm_full;
  logic [HTOT_W-1:0]     h6_q, hh_full;
  logic [SEC_W-1:0]      ss6_q;

  logic                  ov_q;
  logic [ZONES-1:0]      rem_q;
  logic [HOUR_W-1:0]     hh_q;
  logic [MIN_W-1:0]      mm_q;
  logic [SEC_W-1:0]      ss_q;
  logic [DUTY_W-1:0]     duty_q;
  logic                  armed_q, siren_q;

  assign last_w = ~|(rem_q & (rem_q - ZONES'(1)));
  assign take   = !ov_q || (out_o.ready && last_w);
  assign en     = take || !v6_q;
  assign pop_o  = en && avail_i;

  assign sec_prod = SEC_PROD_W'(p1_q) * SEC_PROD_W'(SEC_RECIP);
  assign r4       = p3_q - t3_q;
  assign min_prod = MIN_PROD_W'(s4_q) * MIN_PROD_W'(MIN_RECIP);
  assign hr_prod  = HR_PROD_W'(m5_q) * HR_PROD_W'(HR_RECIP);
  assign ss_full  = s5_q - TICK_W'(m5_q) * TICK_W'(SEC_PER_MIN);
  assign mm_full  = m6_q - MTOT_W'(h6_q) * MTOT_W'(SEC_PER_MIN);
  assign hh_full  = (h6_q >= HTOT_W'(HOURS_PER_DAY)) ? h6_q - HTOT_W'(HOURS_PER_DAY) : h6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en) begin
        v1_q <= avail_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        v5_q <= v4_q;
        v6_q <= v5_q;
      end
      if (take) begin
        ov_q <= v6_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn1_q <= snap_i;
      p1_q  <= SEC_P_W'(snap_i.ticks) * SEC_P_W'(TICK_NUM);
      sn2_q <= sn1_q;
      p2_q  <= p1_q;
      q2_q  <= sec_prod[SEC_SHIFT +: TICK_W];
      sn3_q <= sn2_q;
      p3_q  <= p2_q;
      q3_q  <= q2_q;
      t3_q  <= SEC_P_W'(q2_q) * SEC_P_W'(TICK_DEN);
      sn4_q <= sn3_q;
      // Estimate is exact or one short; fix it with the remainder.
      s4_q  <= q3_q + TICK_W'(r4 >= SEC_P_W'(TICK_DEN));
      sn5_q <= sn4_q;
      s5_q  <= s4_q;
      m5_q  <= min_prod[MIN_SHIFT +: MTOT_W];
      sn6_q <= sn5_q;
      m6_q  <= m5_q;
      h6_q  <= hr_prod[HR_SHIFT +: HTOT_W];
      ss6_q <= ss_full[SEC_W-1:0];
    end
  end

  // Hold the payload per item; drop one fired zone per transfer.
  always_ff @(posedge clk_i) begin
    if (take) begin
      rem_q   <= sn6_q.fired;
      hh_q    <= hh_full[HOUR_W-1:0];
      mm_q    <= mm_full[MIN_W-1:0];
      ss_q    <= ss6_q;
      duty_q  <= sn6_q.duty;
      armed_q <= sn6_q.armed;
      siren_q <= sn6_q.siren_on;
    end else if (out_o.ready) begin
      rem_q <= rem_q & (rem_q - ZONES'(1));
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.alarm_event = |rem_q;
  assign out_o.fired_zone  = zone_id(rem_q);
  assign out_o.hours       = hh_q;
  assign out_o.minutes     = mm_q;
  assign out_o.seconds_out = ss_q;
  assign out_o.duty        = duty_q;
  assign out_o.armed_out   = armed_q;
  assign out_o.siren_on    = siren_q;
  assign out_o.last        = last_w;

  `ZAC_ASSERT_NEXT(a_be_zone_step, clk_i, rst_ni, ov_q && out_o.ready && !last_w,
                   ov_q && ($countones(rem_q) + 1 == $countones($past(rem_q))),
                   "fired zone not retired after transfer")

endmodule

// ----- design/zone_alarm_controller_core.sv -----
// Top level of the four-zone alarm controller: configuration registers, front, queue, back.
//
// Four-zone intruder alarm with time of day, arming, siren timeout and a swept
// siren PWM duty. Items arrive already decoded on in_i; each executed item yields
// one status result on out_o, or one result per fired zone (lowest zone first)
// for a zone sample that fires, with last set on the final one. The block takes
// one item per clock cycle sustained: every action executes in the front's state
// stage, and the input stalls only when the snapshot queue is full, which happens
// when the output is back-pressured or when a zone sample fires more than one
// zone, since the back hands out one result per transfer and holds that item
// until its last result. From input transfer to the first result an item passes
// three front stages (the last one updates the alarm state), the queue and six back
// stages that turn the tick count into hh:mm:ss by reciprocal multiplication, then
// the output register.
// Configuration writes on cfg_we_i/cfg_idx_i/cfg_data_i take effect at the next
// edge and are meant to happen while no item is in flight; writes to unused
// indexes are ignored. No clearing pass is needed after reset.
module zone_alarm_controller_core #(
  parameter int unsigned QUEUE_DEPTH = zac_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  zac_in_if.sink                         in_i,
  zac_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [zac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [zac_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import zac_pkg::*;

  cfg_t  cfg_q;
  logic  push, full, pop, avail;
  snap_t snap_push, snap_pop;

  // Configuration registers: each write lands on the addressed field only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DUTY_HIGH:  cfg_q.duty_high   <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_LOW:   cfg_q.duty_low    <= cfg_data_i[DUTY_W-1:0];
        CFG_START_DUTY: cfg_q.start_duty  <= cfg_data_i[DUTY_W-1:0];
        CFG_SIREN_TICK: cfg_q.siren_ticks <= cfg_data_i[STICK_W-1:0];
        CFG_DAY_TICKS:  cfg_q.day_ticks   <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept, convert set-time seconds, execute the state update.
  zac_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .snap_o (snap_push)
  );

  // Queue of executed snapshots; lets front and back stall independently.
  zac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (snap_push),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (snap_pop)
  );

  // Back: format time of day and fan out one result per fired zone.
  zac_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .snap_i  (snap_pop),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
